// ===== src/stc_pkg.sv =====
// Shared constants for the two-voice stereo chorus: sample width, register
// indexes, reset values, voice modes and the sine table entry function.
// No dependencies.
`timescale 1ns / 1ps

package stc_pkg;

  localparam int SAMPLE_BITS = 24;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 25;

  localparam logic [CFG_IDX_BITS-1:0] REG_VOICE_MODE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_DELAY = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_SPAN = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIX_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP = 3'd4;

  localparam logic [1:0] MODE_A    = 2'd0;
  localparam logic [1:0] MODE_B    = 2'd1;
  localparam logic [1:0] MODE_BOTH = 2'd2;

  localparam logic [18:0] BASE_DELAY_RST = 19'd184320;
  localparam logic [18:0] DEPTH_SPAN_RST = 19'd61440;
  localparam logic [16:0] MIX_LEVEL_RST  = 17'd32768;
  localparam logic [24:0] PHASE_STEP_RST = 25'd44739;
  localparam logic [16:0] MIX_UNITY      = 17'd65536;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [16:0] RATIO_B_Q16  = 17'd85852;

  localparam longint Q30_ONE = 64'sd1073741824;

  // Q30 sine over a quarter wave, odd 7th-order polynomial, floored products
  function automatic longint quarter_sine(longint x);
    longint x2;
    longint p;
    x2 = (x * x) >>> 30;
    p  = 64'sd85569278 - ((x2 * 64'sd5026937) >>> 30);
    p  = 64'sd693598563 - ((x2 * p) >>> 30);
    p  = 64'sd1686629713 - ((x2 * p) >>> 30);
    p  = (x * p) >>> 30;
    if (p > Q30_ONE) p = Q30_ONE;
    if (p < 0) p = 0;
    return p;
  endfunction

  // Modulation depth entry in Q16, for a table of 2^log2_entries entries
  function automatic logic [16:0] sine_entry(longint idx, int log2_entries);
    longint u;
    longint quad;
    longint x;
    longint s;
    u    = (idx << 32) >>> log2_entries;
    quad = (u >>> 30) & 64'sd3;
    x    = u & (Q30_ONE - 1);
    case (quad)
      64'sd0:  s = quarter_sine(x);
      64'sd1:  s = quarter_sine(Q30_ONE - x);
      64'sd2:  s = -quarter_sine(x);
      default: s = -quarter_sine(Q30_ONE - x);
    endcase
    return 17'((Q30_ONE + s) >>> 15);
  endfunction

endpackage

// ===== src/stc_if.sv =====
// Valid/ready channels for the chorus: stereo input pair and mixed output pair.
// Depends on stc_pkg for the sample width.
`timescale 1ns / 1ps

interface stc_in_if import stc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  modport source (output valid, left_in, right_in, input ready);
  modport sink (input valid, left_in, right_in, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

// ===== src/stereo_chorus_two_voice_top.sv =====
// Two-voice stereo chorus: delay-line memories, sine ROM and tap sequencer.
// Depends on stc_pkg and the channel interfaces in stc_if.sv.
`timescale 1ns / 1ps

// Usage
//   sample_in  : one stereo pair per transfer (valid/ready).
//   sample_out : one mixed stereo pair per accepted input pair.
//   cfg_we/cfg_index/cfg_data : register writes, taken on any cycle; write
//     only while no pair is in flight. Indexes 5..7 are ignored.
// Sequence
//   After its input transfer, a pair runs through a setup step, one pass
//   per active tap, the left and right mix steps and an output step: two
//   taps in a single voice mode, four with both voices, none with no voice.
//   The next pair is taken only once the sequencer is idle. Each tap is a ROM
//   read, a delay multiply, two reads of the single delay-line read port and
//   two interpolation steps; the taps share that one read port.
//   sample_in.ready is high only while the sequencer is idle. A finished
//   pair sits in the output register; the next pair is accepted while it
//   waits, and that pair holds in its last step until the register frees.
// Reset
//   rst clears the sequencer and then sweeps both delay lines to zero, one
//   entry a cycle, through every entry; no input is accepted meanwhile.
//   DELAY_DEPTH and SINE_ENTRIES must be powers of two.
module stereo_chorus_two_voice_top import stc_pkg::*; #(
  parameter int DELAY_DEPTH  = 4096,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  stc_in_if.sink                   sample_in,
  stc_out_if.source                sample_out,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int TW = $clog2(SINE_ENTRIES);
  localparam int PW = AW + 8;
  localparam int SB = SAMPLE_BITS;

  typedef logic [16:0] rom_t [SINE_ENTRIES];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      r[i] = sine_entry(longint'(i), TW);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_STEP, S_ROM, S_DLY, S_POS, S_RD1, S_INT1, S_INT2,
    S_MIX_L, S_MIX_R, S_DONE
  } state_t;

  // configuration
  logic [1:0]  voice_mode;
  logic [18:0] base_delay;
  logic [18:0] depth_span;
  logic [16:0] mix_level;
  logic [24:0] phase_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_mode <= MODE_A;
      base_delay <= BASE_DELAY_RST;
      depth_span <= DEPTH_SPAN_RST;
      mix_level  <= MIX_LEVEL_RST;
      phase_step <= PHASE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOICE_MODE: voice_mode <= cfg_data[1:0];
        REG_BASE_DELAY: base_delay <= cfg_data[18:0];
        REG_DEPTH_SPAN: depth_span <= cfg_data[18:0];
        REG_MIX_LEVEL:  mix_level  <= cfg_data[16:0];
        REG_PHASE_STEP: phase_step <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  state_t state;
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] wr_idx;
  logic [31:0]   phase_a;
  logic [31:0]   phase_b;
  logic [32:0]   step_lo;
  logic [31:0]   step_b;
  logic [1:0]    tap;
  logic [16:0]   rom_q;
  logic [19:0]   delay_q;
  logic [AW-1:0] i0;
  logic [7:0]    frac;
  logic signed [SB-1:0]  dry_l;
  logic signed [SB-1:0]  dry_r;
  logic signed [SB-1:0]  s0;
  logic signed [SB+9:0]  prod0;
  logic signed [SB+9:0]  prod1;
  logic signed [SB:0]    wet_l;
  logic signed [SB:0]    wet_r;
  logic signed [SB+17:0] mix_dry;
  logic signed [SB+18:0] mix_wet;
  logic signed [SB-1:0]  y_l;
  logic                  out_valid;
  logic signed [SB-1:0]  out_l;
  logic signed [SB-1:0]  out_r;

  logic use_a;
  logic use_b;
  assign use_a = (voice_mode == MODE_A) || (voice_mode == MODE_BOTH);
  assign use_b = (voice_mode == MODE_B) || (voice_mode == MODE_BOTH);

  logic accept;
  assign sample_in.ready = (state == S_IDLE);
  assign accept = sample_in.valid && sample_in.ready;

  // tap phase: voice select on bit 1, right channel a quarter turn later
  logic [31:0]   tap_phase;
  logic [PW-1:0] pos;
  assign tap_phase = (tap[1] ? phase_b : phase_a) + (tap[0] ? QUARTER_TURN : 32'd0);
  assign pos = {wr_idx, 8'd0} - PW'(delay_q);

  // delay-line memories
  logic [SB-1:0] left_mem  [DELAY_DEPTH];
  logic [SB-1:0] right_mem [DELAY_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SB-1:0] wdata_l;
  logic [SB-1:0] wdata_r;
  logic [AW-1:0] rd_addr;
  logic [SB-1:0] rd_l;
  logic [SB-1:0] rd_r;
  logic signed [SB-1:0] rd_sel;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx;
    wdata_l   = sample_in.left_in;
    wdata_r   = sample_in.right_in;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      wdata_l   = '0;
      wdata_r   = '0;
    end else if (accept) begin
      mem_we = 1'b1;
    end
    rd_addr = (state == S_POS) ? pos[PW-1:8] : i0 + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      left_mem[mem_waddr]  <= wdata_l;
      right_mem[mem_waddr] <= wdata_r;
    end
    rd_l <= left_mem[rd_addr];
    rd_r <= right_mem[rd_addr];
  end

  assign rd_sel = tap[0] ? $signed(rd_r) : $signed(rd_l);

  // arithmetic
  logic [16:0] mix_c;
  logic [16:0] mix_inv;
  logic [35:0] span_prod;
  logic [8:0]  w0;
  logic signed [SB+10:0] interp_sum;
  logic signed [SB+2:0]  interp;
  logic signed [SB:0]    wet_sel;
  logic signed [SB:0]    wet_half;
  logic signed [SB+19:0] mix_sum;
  logic signed [SB+3:0]  mix_shift;
  logic signed [SB-1:0]  mix_sat;
  logic [25:0]           hi_prod;

  always_comb begin
    mix_c      = (mix_level > MIX_UNITY) ? MIX_UNITY : mix_level;
    mix_inv    = MIX_UNITY - mix_c;
    span_prod  = depth_span * rom_q;
    w0         = 9'd256 - {1'b0, frac};
    interp_sum = prod0 + prod1;
    interp     = (SB+3)'(interp_sum >>> 8);
    wet_sel    = (state == S_MIX_L) ? wet_l : wet_r;
    wet_half   = (voice_mode == MODE_BOTH) ? (wet_sel >>> 1) : wet_sel;
    mix_sum    = mix_dry + mix_wet;
    mix_shift  = (SB+4)'(mix_sum >>> 16);
    if (mix_shift > $signed({5'b00000, {(SB-1){1'b1}}})) begin
      mix_sat = {1'b0, {(SB-1){1'b1}}};
    end else if (mix_shift < $signed({5'b11111, {(SB-1){1'b0}}})) begin
      mix_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      mix_sat = mix_shift[SB-1:0];
    end
    hi_prod = phase_step[24:16] * RATIO_B_Q16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      wr_idx    <= '0;
      phase_a   <= '0;
      phase_b   <= QUARTER_TURN;
      out_valid <= 1'b0;
      tap       <= '0;
    end else begin
      if (out_valid && sample_out.ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == AW'(DELAY_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            dry_l   <= sample_in.left_in;
            dry_r   <= sample_in.right_in;
            wet_l   <= '0;
            wet_r   <= '0;
            step_lo <= phase_step[15:0] * RATIO_B_Q16;
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          step_b <= 32'(hi_prod) + 32'((34'(step_lo) + 34'd32768) >> 16);
          if (use_a) begin
            tap   <= 2'd0;
            state <= S_ROM;
          end else if (use_b) begin
            tap   <= 2'd2;
            state <= S_ROM;
          end else begin
            state <= S_MIX_L;
          end
        end
        S_ROM: begin
          rom_q <= SINE_ROM[tap_phase[31 -: TW]];
          state <= S_DLY;
        end
        S_DLY: begin
          delay_q <= {1'b0, base_delay} + span_prod[35:16];
          state   <= S_POS;
        end
        S_POS: begin
          i0    <= pos[PW-1:8];
          frac  <= pos[7:0];
          state <= S_RD1;
        end
        S_RD1: begin
          s0    <= rd_sel;
          state <= S_INT1;
        end
        S_INT1: begin
          prod0 <= s0 * $signed({1'b0, w0});
          prod1 <= rd_sel * $signed({2'b00, frac});
          state <= S_INT2;
        end
        S_INT2: begin
          if (tap[0]) wet_r <= wet_r + (SB+1)'(interp);
          else        wet_l <= wet_l + (SB+1)'(interp);
          if (tap == 2'd0 || tap == 2'd2) begin
            tap   <= tap + 2'd1;
            state <= S_ROM;
          end else if (tap == 2'd1 && use_b) begin
            tap   <= 2'd2;
            state <= S_ROM;
          end else begin
            state <= S_MIX_L;
          end
        end
        S_MIX_L: begin
          mix_dry <= dry_l * $signed({1'b0, mix_inv});
          mix_wet <= wet_half * $signed({1'b0, mix_c});
          state   <= S_MIX_R;
        end
        S_MIX_R: begin
          y_l     <= mix_sat;
          mix_dry <= dry_r * $signed({1'b0, mix_inv});
          mix_wet <= wet_half * $signed({1'b0, mix_c});
          state   <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register frees
          if (!out_valid || sample_out.ready) begin
            out_l     <= y_l;
            out_r     <= mix_sat;
            out_valid <= 1'b1;
            wr_idx    <= wr_idx + AW'(1);
            phase_a   <= phase_a + 32'(phase_step);
            phase_b   <= phase_b + step_b;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample_out.valid     = out_valid;
  assign sample_out.left_out  = out_l;
  assign sample_out.right_out = out_r;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !sample_in.ready)
    else $error("input ready during delay-line clear");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (sample_in.valid && sample_in.ready) |=> !sample_in.ready)
    else $error("second transfer taken while an item is in flight");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || sample_out.ready)) |=>
      (sample_out.valid && wr_idx == $past(wr_idx) + AW'(1)))
    else $error("finished item not loaded into output register");
`endif

endmodule

// ===== verif/stc_chorus_checker.sv =====
// Chorus checker: watches the sample channels and the register write port,
// predicts each mixed stereo pair and compares it with what the block sends.
// Depends on stc_pkg and the channel interfaces in stc_if.sv.
`timescale 1ns / 1ps

module stc_chorus_checker import stc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  stc_in_if                        in_ch,
  stc_out_if                       out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       errors,
  output int                       outstanding
);

  localparam int LINE_LEN  = 4096;
  localparam int TAB_LEN   = 1024;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint SAT_HI  = 64'sd8388607;
  localparam longint SAT_LO  = -64'sd8388608;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } stereo_t;

  logic signed [SAMPLE_BITS-1:0] left_hist [LINE_LEN];
  logic signed [SAMPLE_BITS-1:0] right_hist [LINE_LEN];
  bit [16:0] sweep_tab [TAB_LEN];
  bit [11:0] wr_pos;
  bit [31:0] lfo_a, lfo_b;
  bit [1:0]  mode_q;
  bit [18:0] base_q, depth_q;
  bit [16:0] mix_q;
  bit [24:0] step_q;
  stereo_t   mixed_q[$];

  function automatic longint quarter_wave(longint x);
    longint x2, p;
    x2 = (x * x) >>> 30;
    p  = 64'sd85569278 - ((x2 * 64'sd5026937) >>> 30);
    p  = 64'sd693598563 - ((x2 * p) >>> 30);
    p  = 64'sd1686629713 - ((x2 * p) >>> 30);
    p  = (x * p) >>> 30;
    if (p > ONE_Q30) p = ONE_Q30;
    if (p < 0) p = 0;
    return p;
  endfunction

  initial begin
    longint u, x, s;
    for (int i = 0; i < TAB_LEN; i++) begin
      u = longint'(i) << 22;
      x = u & (ONE_Q30 - 1);
      case ((u >>> 30) & 3)
        0:       s = quarter_wave(x);
        1:       s = quarter_wave(ONE_Q30 - x);
        2:       s = -quarter_wave(x);
        default: s = -quarter_wave(ONE_Q30 - x);
      endcase
      sweep_tab[i] = 17'((ONE_Q30 + s) >>> 15);
    end
  end

  // Interpolated read of one delay line at the delay given by this phase
  function automatic longint delayed_read(bit right_side, bit [31:0] ph);
    longint d, pos, f, s0, s1;
    bit [11:0] i0, i1;
    d   = longint'(base_q) + ((longint'(depth_q) * sweep_tab[ph[31:22]]) >>> 16);
    pos = ((longint'(wr_pos) << 8) + (1 << 20) - (d % (1 << 20))) % (1 << 20);
    i0  = 12'(pos >>> 8);
    i1  = i0 + 12'd1;
    f   = pos & 255;
    s0  = right_side ? right_hist[i0] : left_hist[i0];
    s1  = right_side ? right_hist[i1] : left_hist[i1];
    return (s0 * (256 - f) + s1 * f) >>> 8;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] clamp24(longint v);
    if (v > SAT_HI) return SAMPLE_BITS'(SAT_HI);
    if (v < SAT_LO) return SAMPLE_BITS'(SAT_LO);
    return SAMPLE_BITS'(v);
  endfunction

  function automatic stereo_t chorus_pair(longint dry_l, longint dry_r);
    longint wet_l, wet_r, mixv;
    stereo_t res;
    wet_l = 0;
    wet_r = 0;
    if (mode_q == MODE_A || mode_q == MODE_BOTH) begin
      wet_l += delayed_read(1'b0, lfo_a);
      wet_r += delayed_read(1'b1, lfo_a + QUARTER_TURN);
    end
    if (mode_q == MODE_B || mode_q == MODE_BOTH) begin
      wet_l += delayed_read(1'b0, lfo_b);
      wet_r += delayed_read(1'b1, lfo_b + QUARTER_TURN);
    end
    if (mode_q == MODE_BOTH) begin
      wet_l = wet_l >>> 1;
      wet_r = wet_r >>> 1;
    end
    mixv = (mix_q > MIX_UNITY) ? 65536 : longint'(mix_q);
    res.left  = clamp24((dry_l * (65536 - mixv) + wet_l * mixv) >>> 16);
    res.right = clamp24((dry_r * (65536 - mixv) + wet_r * mixv) >>> 16);
    return res;
  endfunction

  assign outstanding = mixed_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    stereo_t want;
    longint  dl, dr;
    if (rst) begin
      for (int i = 0; i < LINE_LEN; i++) begin
        left_hist[i]  = '0;
        right_hist[i] = '0;
      end
      wr_pos  = '0;
      lfo_a   = '0;
      lfo_b   = QUARTER_TURN;
      mode_q  = MODE_A;
      base_q  = BASE_DELAY_RST;
      depth_q = DEPTH_SPAN_RST;
      mix_q   = MIX_LEVEL_RST;
      step_q  = PHASE_STEP_RST;
      mixed_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (mixed_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output pair %0d %0d", $time,
                   out_ch.left_out, out_ch.right_out);
        end else begin
          want = mixed_q.pop_front();
          if (out_ch.left_out !== want.left) begin
            errors++;
            $display("%0t: left_out expected %0d actual %0d", $time,
                     want.left, out_ch.left_out);
          end
          if (out_ch.right_out !== want.right) begin
            errors++;
            $display("%0t: right_out expected %0d actual %0d", $time,
                     want.right, out_ch.right_out);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        dl = longint'(in_ch.left_in);
        dr = longint'(in_ch.right_in);
        left_hist[wr_pos]  = in_ch.left_in;
        right_hist[wr_pos] = in_ch.right_in;
        mixed_q.push_back(chorus_pair(dl, dr));
        wr_pos = wr_pos + 12'd1;
        lfo_a  = lfo_a + step_q;
        lfo_b  = lfo_b + 32'((longint'(step_q) * RATIO_B_Q16 + 32768) >>> 16);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_VOICE_MODE: mode_q  = cfg_data[1:0];
          REG_BASE_DELAY: base_q  = cfg_data[18:0];
          REG_DEPTH_SPAN: depth_q = cfg_data[18:0];
          REG_MIX_LEVEL:  mix_q   = cfg_data[16:0];
          REG_PHASE_STEP: step_q  = cfg_data[24:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/stereo_chorus_two_voice_top_tb.sv =====
// Top of the chorus testbench: clock, reset, register writes, sample stimulus
// and output back-pressure; the verdict comes from stc_chorus_checker.
// Depends on stc_pkg, stc_if.sv, the chorus top and the checker.
`timescale 1ns / 1ps

module stereo_chorus_two_voice_top_tb;
  import stc_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int   errors;
  int   outstanding;
  bit   steady;

  stc_in_if  in_ch ();
  stc_out_if out_ch ();

  stereo_chorus_two_voice_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (in_ch),
    .sample_out (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  stc_chorus_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("stereo_chorus_two_voice_top_tb: errors");
    $finish;
  end

  // Output side: random stall before each transfer unless running steady
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_pair(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.left_in  = l;
    in_ch.right_in = r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Hold until the block has drained, then let its pipeline settle
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_chorus(logic [1:0] mode, logic [18:0] base, logic [18:0] depth,
                            logic [16:0] mix, logic [24:0] step);
    drain();
    write_reg(REG_VOICE_MODE, CFG_DATA_BITS'(mode));
    write_reg(REG_BASE_DELAY, CFG_DATA_BITS'(base));
    write_reg(REG_DEPTH_SPAN, CFG_DATA_BITS'(depth));
    write_reg(REG_MIX_LEVEL, CFG_DATA_BITS'(mix));
    write_reg(REG_PHASE_STEP, step);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] any_sample();
    case ($urandom_range(0, 9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.left_in  = '0;
    in_ch.right_in = '0;
    steady         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes under reset settings, then zero delay, odd registers, both voices and voice B
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h800000, 24'h7FFFFF);
    send_pair(24'h000000, 24'hFFFFFF);
    send_pair(24'h555555, 24'hAAAAAA);
    send_pair(24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h800000, 24'h800000);
    set_chorus(MODE_A, 19'd0, 19'd0, MIX_UNITY, 25'd0);
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h123456, 24'hEDCBA9);
    set_chorus(2'd3, 19'h7FFFF, 19'h7FFFF, 17'h1FFFF, 25'h1FFFFFF);
    write_reg(3'd5, '1);
    write_reg(3'd6, '0);
    write_reg(3'd7, '1);
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h800000, 24'h7FFFFF);
    set_chorus(MODE_BOTH, 19'h7FFFF, 19'h7FFFF, MIX_UNITY, 25'h1000000);
    for (int i = 0; i < 6; i++) send_pair(24'h7FFFFF, 24'h800000);
    set_chorus(MODE_B, 19'd256, 19'd0, 17'd0, 25'd44739);
    send_pair(24'h800000, 24'h7FFFFF);
    send_pair(24'h000001, 24'hFFFFFE);

    // Random phases, each with its own settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_chorus(MODE_A, 19'd184320, 19'd61440, 17'd32768, 25'd44739);
        1: set_chorus(MODE_B, 19'd0, 19'h7FFFF, 17'd65536, 25'h1FFFFFF);
        2: set_chorus(MODE_BOTH, 19'd512, 19'd1024, 17'd40000, 25'd3000000);
        3: set_chorus(MODE_BOTH, 19'h7FFFF, 19'd0, 17'h1FFFF, 25'd0);
        4: set_chorus(2'd3, 19'($urandom), 19'($urandom), 17'($urandom), 25'($urandom));
        default: set_chorus(2'($urandom_range(0, 2)), 19'($urandom), 19'($urandom),
                            17'($urandom_range(0, 65536)), 25'($urandom));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      n = 118;
      for (int i = 0; i < n; i++) begin
        if (ph == 2 && i % 40 == 39) drain();
        send_pair(any_sample(), any_sample());
      end
    end
    steady = 1'b0;

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("stereo_chorus_two_voice_top_tb: clean");
    end else begin
      $display("stereo_chorus_two_voice_top_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/stc_pkg.sv
src/stc_if.sv
src/stereo_chorus_two_voice_top.sv
verif/stc_chorus_checker.sv
verif/stereo_chorus_two_voice_top_tb.sv
